@@ hdl/afr_pkg.sv @@
package afr_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned HDR_N   = 8;
   localparam int unsigned HDR_AW  = 3;

   localparam logic [CHAR_W-1:0]  CHAR_START = 8'h3A;
   localparam logic [CHAR_W-1:0]  CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0]  CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'hFF;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h41;
   localparam logic [INDEX_W-1:0] MAX_INDEX_RESET = 10'd1000;
   localparam logic [INDEX_W-1:0] MIN_LRC_INDEX   = 10'd4;

   typedef struct packed {
      logic               lrc_ok;
      logic [CHAR_W-1:0]  station_address;
      logic [CHAR_W-1:0]  function_code;
      logic [CHAR_W-1:0]  data_first;
      logic [CHAR_W-1:0]  data_second;
      logic [CHAR_W-1:0]  received_lrc;
      logic [CHAR_W-1:0]  computed_lrc;
      logic [INDEX_W-1:0] frame_index;
   } result_type;

   // letters get +9; no range check on the character
   function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [4:0] d;
      d = {1'b0, c[3:0]};
      if (c >= CHAR_ALPHA) begin
         d = d + 5'd9;
      end
      return d;
   endfunction

   function automatic logic [CHAR_W-1:0] decode_pair(input logic [CHAR_W-1:0] high,
                                                     input logic [CHAR_W-1:0] low);
      logic [4:0] hd;
      logic [4:0] ld;
      hd = hex_digit(high);
      ld = hex_digit(low);
      return {hd[3:0], 4'b0000} | {3'b000, ld};
   endfunction

endpackage

@@ hdl/ascii_frame_receiver_lrc.sv @@
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  req_rx_char
// rsp      out  rsp_valid / rsp_stall  rsp_lrc_ok .. rsp_frame_index
// csr      in   csr_write_enable       csr_write_data (max_frame_index)
//
// One character per cycle while req_stall is low. A result appears in the
// cycle after the LF item is taken, from the output register. req_stall is
// high only while that register holds a result and rsp_stall is high.
// Synchronous reset returns to hunting and sets max_frame_index to 1000.
module ascii_frame_receiver_lrc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [afr_pkg::CHAR_W-1:0]   req_rx_char,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_lrc_ok,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_station_address,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_function_code,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_data_first,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_data_second,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_received_lrc,
   output logic [afr_pkg::CHAR_W-1:0]   rsp_computed_lrc,
   output logic [afr_pkg::INDEX_W-1:0]  rsp_frame_index,
   input  logic                         csr_write_enable,
   input  logic [afr_pkg::INDEX_W-1:0]  csr_write_data
);

   logic [afr_pkg::INDEX_W-1:0] max_index_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   afr_pkg::result_type         rsp_data_ff;
   afr_pkg::result_type         result;
   logic                        char_take;
   logic                        emit;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign char_take = req_valid && !req_stall;

   afr_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .char_take (char_take),
      .rx_char   (req_rx_char),
      .max_index (max_index_ff),
      .emit      (emit),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_index_ff <= afr_pkg::MAX_INDEX_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_index_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_lrc_ok          = rsp_data_ff.lrc_ok;
   assign rsp_station_address = rsp_data_ff.station_address;
   assign rsp_function_code   = rsp_data_ff.function_code;
   assign rsp_data_first      = rsp_data_ff.data_first;
   assign rsp_data_second     = rsp_data_ff.data_second;
   assign rsp_received_lrc    = rsp_data_ff.received_lrc;
   assign rsp_computed_lrc    = rsp_data_ff.computed_lrc;
   assign rsp_frame_index     = rsp_data_ff.frame_index;

endmodule

@@ hdl/afr_framer.sv @@
module afr_framer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         char_take,
   input  logic [afr_pkg::CHAR_W-1:0]   rx_char,
   input  logic [afr_pkg::INDEX_W-1:0]  max_index,
   output logic                         emit,
   output afr_pkg::result_type          result
);

   logic                        in_frame_ff, in_frame_in;
   logic [afr_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [afr_pkg::CHAR_W-1:0]  sum_ff, sum_in;
   logic [afr_pkg::CHAR_W-1:0]  recent_ff [3];
   logic [afr_pkg::CHAR_W-1:0]  recent_in [3];
   logic [afr_pkg::CHAR_W-1:0]  hdr_ff [afr_pkg::HDR_N];
   logic [afr_pkg::CHAR_W-1:0]  hdr_in [afr_pkg::HDR_N];
   logic [afr_pkg::CHAR_W-1:0]  hdr_eff [afr_pkg::HDR_N];

   logic                        real_char;
   logic                        step;
   logic [afr_pkg::INDEX_W:0]   next_wide;
   logic [afr_pkg::INDEX_W-1:0] next_idx;
   logic                        overflow;
   logic                        frame_end;
   logic                        hdr_wr;
   logic [afr_pkg::INDEX_W-1:0] wr_pos;
   logic [afr_pkg::HDR_AW-1:0]  wr_idx;
   logic [afr_pkg::CHAR_W-1:0]  body_sum;
   logic [afr_pkg::CHAR_W-1:0]  calc_lrc;
   logic [afr_pkg::CHAR_W-1:0]  rx_lrc;
   logic                        long_enough;

   assign real_char = char_take && (rx_char != afr_pkg::CHAR_NONE);
   assign step      = real_char && in_frame_ff;
   assign next_wide = {1'b0, idx_ff} + 11'd1;
   assign next_idx  = next_wide[afr_pkg::INDEX_W-1:0];
   assign overflow  = next_wide > {1'b0, max_index};
   assign frame_end = (rx_char == afr_pkg::CHAR_LF) && (recent_ff[0] == afr_pkg::CHAR_CR);
   assign emit      = step && !overflow && frame_end;

   // header slot for indices 1..8
   assign wr_pos = next_idx - 10'd1;
   assign wr_idx = wr_pos[afr_pkg::HDR_AW-1:0];
   assign hdr_wr = step && !overflow && (next_idx inside {[10'd1:10'd8]});

   always_comb begin
      for (int k = 0; k < afr_pkg::HDR_N; k++) begin
         hdr_eff[k] = (hdr_wr && (wr_idx == afr_pkg::HDR_AW'(k))) ? rx_char : hdr_ff[k];
      end
   end

   // sum of characters 1 .. n-4
   assign body_sum    = sum_ff - recent_ff[0] - recent_ff[1] - recent_ff[2];
   assign calc_lrc    = 8'd0 - body_sum;
   assign rx_lrc      = afr_pkg::decode_pair(recent_ff[2], recent_ff[1]);
   assign long_enough = next_idx >= afr_pkg::MIN_LRC_INDEX;

   always_comb begin
      result.lrc_ok          = long_enough && (rx_lrc == calc_lrc);
      result.station_address = afr_pkg::decode_pair(hdr_eff[0], hdr_eff[1]);
      result.function_code   = afr_pkg::decode_pair(hdr_eff[2], hdr_eff[3]);
      result.data_first      = afr_pkg::decode_pair(hdr_eff[4], hdr_eff[5]);
      result.data_second     = afr_pkg::decode_pair(hdr_eff[6], hdr_eff[7]);
      result.received_lrc    = long_enough ? rx_lrc : 8'd0;
      result.computed_lrc    = long_enough ? calc_lrc : 8'd0;
      result.frame_index     = next_idx;
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      recent_in   = recent_ff;
      hdr_in      = hdr_eff;
      if (real_char && !in_frame_ff) begin
         if (rx_char == afr_pkg::CHAR_START) begin
            in_frame_in = 1'b1;
            idx_in      = '0;
            sum_in      = '0;
            for (int k = 0; k < 3; k++) begin
               recent_in[k] = '0;
            end
            for (int k = 0; k < afr_pkg::HDR_N; k++) begin
               hdr_in[k] = '0;
            end
         end
      end else if (step) begin
         if (overflow) begin
            in_frame_in = 1'b0;
            idx_in      = '0;
         end else begin
            idx_in = next_idx;
            if (frame_end) begin
               in_frame_in = 1'b0;
            end else begin
               sum_in       = sum_ff + rx_char;
               recent_in[2] = recent_ff[1];
               recent_in[1] = recent_ff[0];
               recent_in[0] = rx_char;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      recent_ff <= recent_in;
      hdr_ff    <= hdr_in;
   end

endmodule
